### rtl/ced_pkg.sv
// shared types, constants and small datapath functions of the canny edge front end
// no dependencies; ced_isqrt and the front end import this package
package ced_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_HEIGHT_DEF = 1024;
	localparam int unsigned MIN_SIZE       = 3;

	localparam int unsigned CFG_BITS  = 11;
	localparam int unsigned PIX_BITS  = 8;
	localparam int unsigned MAG_BITS  = 11;
	localparam int unsigned GRAD_BITS = 13;
	localparam int unsigned SQ_BITS   = 22;

	// tan(22.5 deg) as 106/256
	localparam int unsigned TAN_NUM   = 106;
	localparam int unsigned TAN_SHIFT = 8;

	localparam int unsigned RESET_WIDTH  = 640;
	localparam int unsigned RESET_HEIGHT = 480;
	localparam int unsigned RESET_LOW    = 50;
	localparam int unsigned RESET_HIGH   = 100;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH    = 2'd0,
		REG_FRAME_HEIGHT   = 2'd1,
		REG_LOW_THRESHOLD  = 2'd2,
		REG_HIGH_THRESHOLD = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEC_HORZ     = 2'd0,
		SEC_DIAG_POS = 2'd1,
		SEC_VERT     = 2'd2,
		SEC_DIAG_NEG = 2'd3
	} sector_t;

	typedef enum logic [1:0] {
		CLS_NONE   = 2'd0,
		CLS_WEAK   = 2'd1,
		CLS_STRONG = 2'd2
	} edge_cls_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DER,
		ST_DECIDE,
		ST_RAW,
		ST_SMOOTH,
		ST_GRAD,
		ST_SQS,
		ST_SQRT,
		ST_GWIN,
		ST_OUT
	} ced_state_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] pixel;
		logic                flush;
	} pix_item_t;

	typedef struct packed {
		logic [1:0]          edge_class;
		logic [MAG_BITS-1:0] suppressed_magnitude;
		logic                last_of_frame;
	} res_item_t;

	typedef logic [8:0][PIX_BITS-1:0]  pix_win_t;
	typedef logic [8:0][GRAD_BITS-1:0] grad_win_t;

	function automatic logic [PIX_BITS-1:0] blur3x3(input pix_win_t s);
		logic [11:0] corner;
		logic [11:0] side;
		logic [11:0] sum;
		corner = 12'(s[0]) + 12'(s[2]) + 12'(s[6]) + 12'(s[8]);
		side   = 12'(s[1]) + 12'(s[3]) + 12'(s[5]) + 12'(s[7]);
		sum    = corner + (side << 1) + (12'(s[4]) << 2);
		return sum[11:4];
	endfunction

	// shift a window one column left; new right column from two line reads and the new value
	function automatic pix_win_t shift_pix(input pix_win_t s, input logic [PIX_BITS-1:0] top,
			input logic [PIX_BITS-1:0] mid, input logic [PIX_BITS-1:0] bot);
		pix_win_t r;
		r    = s;
		r[0] = s[1];
		r[1] = s[2];
		r[3] = s[4];
		r[4] = s[5];
		r[6] = s[7];
		r[7] = s[8];
		r[2] = top;
		r[5] = mid;
		r[8] = bot;
		return r;
	endfunction

	function automatic grad_win_t shift_grad(input grad_win_t s, input logic [GRAD_BITS-1:0] top,
			input logic [GRAD_BITS-1:0] mid, input logic [GRAD_BITS-1:0] bot);
		grad_win_t r;
		r    = s;
		r[0] = s[1];
		r[1] = s[2];
		r[3] = s[4];
		r[4] = s[5];
		r[6] = s[7];
		r[7] = s[8];
		r[2] = top;
		r[5] = mid;
		r[8] = bot;
		return r;
	endfunction

endpackage

### rtl/ced_line_mem.sv
// two-line store: two banks of one line each, one read and one write address per cycle
// registered read data; no package dependency
module ced_line_mem #(
	parameter int unsigned DATA_BITS = 8,
	parameter int unsigned DEPTH     = 1024
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(DEPTH)-1:0]     rd_addr,
	input  logic                         wr_en,
	input  logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  logic [DATA_BITS-1:0]         wr_lo,
	input  logic [DATA_BITS-1:0]         wr_hi,
	output logic [DATA_BITS-1:0]         rd_lo,
	output logic [DATA_BITS-1:0]         rd_hi
);

	logic [DATA_BITS-1:0] bank_lo_q [DEPTH];
	logic [DATA_BITS-1:0] bank_hi_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bank_lo_q[wr_addr] <= wr_lo;
			bank_hi_q[wr_addr] <= wr_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_lo <= bank_lo_q[rd_addr];
			rd_hi <= bank_hi_q[rd_addr];
		end
	end

endmodule

### rtl/ced_isqrt.sv
// floor integer square root, one result bit per cycle
// depends on ced_pkg for the operand width default
module ced_isqrt #(
	parameter int unsigned OP_BITS = ced_pkg::SQ_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [OP_BITS-1:0]     operand,
	output logic                   done,
	output logic [OP_BITS/2-1:0]   root
);
	import ced_pkg::*;

	localparam int unsigned RT_BITS  = OP_BITS / 2;
	localparam int unsigned REM_BITS = RT_BITS + 3;
	localparam int unsigned CNT_BITS = $clog2(RT_BITS + 1);

	logic [OP_BITS-1:0]  op_q;
	logic [REM_BITS-1:0] rem_q;
	logic [RT_BITS-1:0]  root_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [REM_BITS-1:0] rem_in;
	logic [REM_BITS-1:0] trial;

	always_comb begin
		rem_in = {rem_q[REM_BITS-3:0], op_q[OP_BITS-1 -: 2]};
		trial  = REM_BITS'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(RT_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q <= op_q << 2;
			if (rem_in >= trial) begin
				rem_q  <= rem_in - trial;
				root_q <= {root_q[RT_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= rem_in;
				root_q <= {root_q[RT_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### rtl/ced_div.sv
// restoring divider, one quotient bit per cycle, for recomputing row and column
// no package dependency
module ced_div #(
	parameter int unsigned NUM_BITS = 21,
	parameter int unsigned DEN_BITS = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] numer,
	input  logic [DEN_BITS-1:0] denom,
	output logic                done,
	output logic [NUM_BITS-1:0] quot,
	output logic [DEN_BITS-1:0] remain
);

	localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DEN_BITS:0]   part;

	assign part = {rem_q, quo_q[NUM_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			if (part >= {1'b0, den_q}) begin
				rem_q <= DEN_BITS'(part - {1'b0, den_q});
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= part[DEN_BITS-1:0];
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign quot   = quo_q;
	assign remain = rem_q;

endmodule

### rtl/canny_edge_front_end_stream.sv
// canny edge front end: blur, sobel, magnitude, non-maximum suppression, double threshold
// states per item: prep, decide, raw, smooth, gradient, square root, gradient window, output
// no new item is taken before the sequencer is idle again, so the bit-serial square root
// bounds throughput; after a size change the next item also runs the position divider once
// reset: registers back to 640x480, thresholds 50/100, windows and positions cleared;
// line stores are not cleared, their unwritten entries only feed border positions
// depends on ced_pkg, ced_line_mem, ced_isqrt, ced_div
module canny_edge_front_end_stream #(
	parameter int unsigned MAX_WIDTH  = ced_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = ced_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  ced_pkg::pix_item_t             pix_data,
	output logic                           res_valid,
	input  logic                           res_stall,
	output ced_pkg::res_item_t             res_data,
	input  logic                           cfg_write,
	input  logic [1:0]                     cfg_index,
	input  logic [ced_pkg::CFG_BITS-1:0]   cfg_data
);
	import ced_pkg::*;

	localparam int unsigned WB = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HB = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned AB = $clog2(MAX_WIDTH);
	localparam int unsigned RB = $clog2(MAX_HEIGHT + 4);
	localparam int unsigned PB = $clog2(MAX_WIDTH * MAX_HEIGHT + 3 * MAX_WIDTH + 4);

	// row/column of one stream position; act means the position has reached zero
	typedef struct packed {
		logic          act;
		logic [RB-1:0] row;
		logic [AB-1:0] col;
	} pos_t;

	localparam pos_t POS_IDLE  = '{act: 1'b0, row: '0, col: '0};
	localparam pos_t POS_START = '{act: 1'b1, row: '0, col: '0};

	// configuration
	logic [CFG_BITS-1:0] frame_width_q, frame_height_q, low_thr_q, high_thr_q;
	logic [WB-1:0]       wc;
	logic [HB-1:0]       hc;
	logic [PB-1:0]       n_q, span_q;
	logic                dirty_q;

	// control and positions: pos_q[k] is the item count minus k*(width+1)
	ced_state_t          st_q, st_d;
	logic [PB-1:0]       t_q;
	pos_t                pos_q [4];
	pix_item_t           pix_q;
	logic [PIX_BITS-1:0] v_q;

	// windows
	pix_win_t            raw_win_q, smooth_win_q;
	grad_win_t           grad_win_q;

	// gradient datapath registers
	logic [19:0]         sqx_q, sqy_q;
	sector_t             sec_q;
	logic                gkeep_q;

	// output register
	logic                res_valid_q;
	res_item_t           res_q;

	// memory, divider and square root hookups
	logic                mem_rd;
	logic [2:0]          mem_wr;
	logic [PIX_BITS-1:0] raw_lo, raw_hi, smo_lo, smo_hi;
	logic [GRAD_BITS-1:0] grd_lo, grd_hi;
	logic                div_start, div_done;
	logic [PB-1:0]       div_quot;
	logic [WB-1:0]       div_rem;
	logic                sq_start, sq_done;
	logic [MAG_BITS-1:0] sq_root;

	logic                out_free;
	logic [PIX_BITS-1:0] sval;
	logic [GRAD_BITS-1:0] gval;
	res_item_t           res_n;
	logic                c3_ok, last_n;

	// ---------------------------------------------------------------- helpers

	function automatic logic centre_ok(input pos_t p, input logic [HB-1:0] h);
		return p.act && (32'(p.row) < 32'(h));
	endfunction

	function automatic logic on_border(input pos_t p, input logic [WB-1:0] w,
			input logic [HB-1:0] h);
		return (p.row == '0) || (32'(p.row) == 32'(h) - 32'd1) ||
			(p.col == '0) || (32'(p.col) == 32'(w) - 32'd1);
	endfunction

	// one position forward in raster order
	function automatic pos_t step_fwd(input pos_t p, input logic [WB-1:0] w);
		pos_t r;
		r = p;
		if (WB'(p.col) == w - WB'(1)) begin
			r.col = '0;
			r.row = p.row + RB'(1);
		end else begin
			r.col = p.col + AB'(1);
		end
		return r;
	endfunction

	// width+1 positions back; inactive when it falls before zero
	function automatic pos_t step_back(input pos_t p, input logic [WB-1:0] w);
		pos_t r;
		r = POS_IDLE;
		if (p.act) begin
			if (p.col == '0) begin
				if (p.row >= RB'(2)) begin
					r.act = 1'b1;
					r.row = p.row - RB'(2);
					r.col = AB'(w - WB'(1));
				end
			end else if (p.row != '0) begin
				r.act = 1'b1;
				r.row = p.row - RB'(1);
				r.col = p.col - AB'(1);
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- frame size

	always_comb begin
		if (frame_width_q < CFG_BITS'(MIN_SIZE))
			wc = WB'(MIN_SIZE);
		else if (32'(frame_width_q) > MAX_WIDTH)
			wc = WB'(MAX_WIDTH);
		else
			wc = WB'(frame_width_q);
		if (frame_height_q < CFG_BITS'(MIN_SIZE))
			hc = HB'(MIN_SIZE);
		else if (32'(frame_height_q) > MAX_HEIGHT)
			hc = HB'(MAX_HEIGHT);
		else
			hc = HB'(frame_height_q);
	end

	// frame pixel count and drain span, registered from the clamped width and height
	always_ff @(posedge clk) begin
		n_q    <= PB'(wc) * PB'(hc);
		span_q <= PB'(wc) * PB'(hc) + PB'(wc) + PB'(wc) + PB'(wc) + PB'(3);
	end

	// ---------------------------------------------------------------- line stores

	ced_line_mem #(.DATA_BITS(PIX_BITS), .DEPTH(MAX_WIDTH)) u_raw_mem (
		.clk(clk), .rd_en(mem_rd), .rd_addr(pos_q[0].col),
		.wr_en(mem_wr[0]), .wr_addr(pos_q[0].col), .wr_lo(raw_hi), .wr_hi(v_q),
		.rd_lo(raw_lo), .rd_hi(raw_hi)
	);

	ced_line_mem #(.DATA_BITS(PIX_BITS), .DEPTH(MAX_WIDTH)) u_smooth_mem (
		.clk(clk), .rd_en(mem_rd), .rd_addr(pos_q[1].col),
		.wr_en(mem_wr[1]), .wr_addr(pos_q[1].col), .wr_lo(smo_hi), .wr_hi(sval),
		.rd_lo(smo_lo), .rd_hi(smo_hi)
	);

	ced_line_mem #(.DATA_BITS(GRAD_BITS), .DEPTH(MAX_WIDTH)) u_grad_mem (
		.clk(clk), .rd_en(mem_rd), .rd_addr(pos_q[2].col),
		.wr_en(mem_wr[2]), .wr_addr(pos_q[2].col), .wr_lo(grd_hi), .wr_hi(gval),
		.rd_lo(grd_lo), .rd_hi(grd_hi)
	);

	// ---------------------------------------------------------------- shared units

	ced_div #(.NUM_BITS(PB), .DEN_BITS(WB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .numer(t_q), .denom(wc),
		.done(div_done), .quot(div_quot), .remain(div_rem)
	);

	ced_isqrt #(.OP_BITS(SQ_BITS)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.operand(SQ_BITS'(sqx_q) + SQ_BITS'(sqy_q)),
		.done(sq_done), .root(sq_root)
	);

	// ---------------------------------------------------------------- stage values

	// blurred value entering the smooth stage; border copies the centre
	always_comb begin
		sval = '0;
		if (centre_ok(pos_q[1], hc))
			sval = on_border(pos_q[1], wc, hc) ? raw_win_q[4] : blur3x3(raw_win_q);
	end

	// magnitude and sector entering the gradient stage
	assign gval = gkeep_q ? {sec_q, sq_root} : '0;

	// suppression and threshold on the gradient window centre
	always_comb begin
		logic [MAG_BITS-1:0] m, a, b;
		m = grad_win_q[4][MAG_BITS-1:0];
		case (sector_t'(grad_win_q[4][GRAD_BITS-1:MAG_BITS]))
			SEC_HORZ: begin
				a = grad_win_q[3][MAG_BITS-1:0];
				b = grad_win_q[5][MAG_BITS-1:0];
			end
			SEC_DIAG_POS: begin
				a = grad_win_q[0][MAG_BITS-1:0];
				b = grad_win_q[8][MAG_BITS-1:0];
			end
			SEC_VERT: begin
				a = grad_win_q[1][MAG_BITS-1:0];
				b = grad_win_q[7][MAG_BITS-1:0];
			end
			default: begin
				a = grad_win_q[2][MAG_BITS-1:0];
				b = grad_win_q[6][MAG_BITS-1:0];
			end
		endcase
		if (on_border(pos_q[3], wc, hc) || m < a || m < b)
			m = '0;
		c3_ok  = centre_ok(pos_q[3], hc);
		last_n = c3_ok && (32'(pos_q[3].row) == 32'(hc) - 32'd1) &&
			(32'(pos_q[3].col) == 32'(wc) - 32'd1);
		res_n.suppressed_magnitude = m;
		res_n.last_of_frame        = last_n;
		if (m > high_thr_q)
			res_n.edge_class = CLS_STRONG;
		else if (m > low_thr_q)
			res_n.edge_class = CLS_WEAK;
		else
			res_n.edge_class = CLS_NONE;
	end

	assign out_free = !res_valid_q || !res_stall;

	// ---------------------------------------------------------------- sequencer

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_d;
	end

	always_comb begin
		st_d      = st_q;
		mem_rd    = 1'b0;
		mem_wr    = '0;
		div_start = 1'b0;
		sq_start  = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (pix_valid)
					st_d = ST_PREP;
			end
			ST_PREP: begin
				// wrap past the drain first, else rebuild positions after a size change
				if (t_q >= span_q) begin
					st_d = ST_DECIDE;
				end else if (dirty_q) begin
					div_start = 1'b1;
					st_d      = ST_DIV;
				end else begin
					st_d = ST_DECIDE;
				end
			end
			ST_DIV: begin
				if (div_done)
					st_d = ST_DER;
			end
			ST_DER: begin
				st_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				// flush inside the frame is dropped with no advance
				if (t_q < n_q && pix_q.flush) begin
					st_d = ST_IDLE;
				end else begin
					mem_rd = 1'b1;
					st_d   = ST_RAW;
				end
			end
			ST_RAW: begin
				mem_wr[0] = pos_q[0].act;
				st_d      = ST_SMOOTH;
			end
			ST_SMOOTH: begin
				mem_wr[1] = pos_q[1].act;
				st_d      = ST_GRAD;
			end
			ST_GRAD: begin
				st_d = ST_SQS;
			end
			ST_SQS: begin
				sq_start = 1'b1;
				st_d     = ST_SQRT;
			end
			ST_SQRT: begin
				if (sq_done)
					st_d = ST_GWIN;
			end
			ST_GWIN: begin
				mem_wr[2] = pos_q[2].act;
				st_d      = ST_OUT;
			end
			ST_OUT: begin
				// wait only when a result must go out and the register is still full and stalled
				if (!c3_ok || out_free)
					st_d = ST_IDLE;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	assign pix_stall = (st_q != ST_IDLE);

	// ---------------------------------------------------------------- datapath

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_BITS'(RESET_WIDTH);
			frame_height_q <= CFG_BITS'(RESET_HEIGHT);
			low_thr_q      <= CFG_BITS'(RESET_LOW);
			high_thr_q     <= CFG_BITS'(RESET_HIGH);
			dirty_q        <= 1'b0;
			t_q            <= '0;
			pos_q[0]       <= POS_START;
			pos_q[1]       <= POS_IDLE;
			pos_q[2]       <= POS_IDLE;
			pos_q[3]       <= POS_IDLE;
			raw_win_q      <= '0;
			smooth_win_q   <= '0;
			grad_win_q     <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;

			case (st_q)
				ST_PREP: begin
					if (t_q >= span_q) begin
						t_q      <= '0;
						pos_q[0] <= POS_START;
						pos_q[1] <= POS_IDLE;
						pos_q[2] <= POS_IDLE;
						pos_q[3] <= POS_IDLE;
						dirty_q  <= 1'b0;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						pos_q[0].act <= 1'b1;
						pos_q[0].row <= RB'(div_quot);
						pos_q[0].col <= AB'(div_rem);
					end
				end
				ST_DER: begin
					pos_q[1] <= step_back(pos_q[0], wc);
					pos_q[2] <= step_back(step_back(pos_q[0], wc), wc);
					pos_q[3] <= step_back(step_back(step_back(pos_q[0], wc), wc), wc);
					dirty_q  <= 1'b0;
				end
				ST_RAW: begin
					if (pos_q[0].act)
						raw_win_q <= shift_pix(raw_win_q, raw_lo, raw_hi, v_q);
				end
				ST_SMOOTH: begin
					if (pos_q[1].act)
						smooth_win_q <= shift_pix(smooth_win_q, smo_lo, smo_hi, sval);
				end
				ST_GWIN: begin
					if (pos_q[2].act)
						grad_win_q <= shift_grad(grad_win_q, grd_lo, grd_hi, gval);
				end
				ST_OUT: begin
					if (!c3_ok || out_free) begin
						if (c3_ok)
							res_valid_q <= 1'b1;
						if (last_n) begin
							// frame done: counters back to the first position
							t_q      <= '0;
							pos_q[0] <= POS_START;
							pos_q[1] <= POS_IDLE;
							pos_q[2] <= POS_IDLE;
							pos_q[3] <= POS_IDLE;
						end else begin
							t_q      <= t_q + PB'(1);
							pos_q[0] <= step_fwd(pos_q[0], wc);
							for (int k = 1; k < 4; k++) begin
								if (pos_q[k].act)
									pos_q[k] <= step_fwd(pos_q[k], wc);
								else if (pos_q[k-1].act && pos_q[k-1].row == RB'(1) &&
										pos_q[k-1].col == '0)
									pos_q[k] <= POS_START;
							end
						end
					end
				end
				default: begin
				end
			endcase

			// configuration last so a width or height write marks positions stale
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_FRAME_WIDTH: begin
						frame_width_q <= cfg_data;
						dirty_q       <= 1'b1;
					end
					REG_FRAME_HEIGHT: begin
						frame_height_q <= cfg_data;
						dirty_q        <= 1'b1;
					end
					REG_LOW_THRESHOLD:  low_thr_q  <= cfg_data;
					REG_HIGH_THRESHOLD: high_thr_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		logic [9:0] gxp, gxn, gyp, gyn, ax, ay;
		if (st_q == ST_IDLE && pix_valid)
			pix_q <= pix_data;
		if (st_q == ST_DECIDE)
			v_q <= (t_q < n_q) ? pix_q.pixel : '0;
		if (st_q == ST_OUT && c3_ok && out_free)
			res_q <= res_n;
		if (st_q == ST_GRAD) begin
			gxp = 10'(smooth_win_q[2]) + (10'(smooth_win_q[5]) << 1) + 10'(smooth_win_q[8]);
			gxn = 10'(smooth_win_q[0]) + (10'(smooth_win_q[3]) << 1) + 10'(smooth_win_q[6]);
			gyp = 10'(smooth_win_q[6]) + (10'(smooth_win_q[7]) << 1) + 10'(smooth_win_q[8]);
			gyn = 10'(smooth_win_q[0]) + (10'(smooth_win_q[1]) << 1) + 10'(smooth_win_q[2]);
			ax  = (gxp >= gxn) ? gxp - gxn : gxn - gxp;
			ay  = (gyp >= gyn) ? gyp - gyn : gyn - gyp;
			sqx_q <= 20'(ax) * 20'(ax);
			sqy_q <= 20'(ay) * 20'(ay);
			// sector compare against tan(22.5 deg) as 106/256
			if ((18'(ay) << TAN_SHIFT) <= 18'(ax) * 18'(TAN_NUM))
				sec_q <= SEC_HORZ;
			else if ((18'(ax) << TAN_SHIFT) <= 18'(ay) * 18'(TAN_NUM))
				sec_q <= SEC_VERT;
			else if ((gxp > gxn) == (gyp > gyn))
				sec_q <= SEC_DIAG_POS;
			else
				sec_q <= SEC_DIAG_NEG;
			gkeep_q <= centre_ok(pos_q[2], hc) && !on_border(pos_q[2], wc, hc);
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// ---------------------------------------------------------------- checks

	// a later stage position never runs without the one ahead of it
	a_pos_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q[3].act |-> pos_q[2].act) and (pos_q[2].act |-> pos_q[1].act))
		else $error("stage position active ahead of its predecessor");

	// the raw column used for line store access lies inside the current width
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RAW |-> 32'(pos_q[0].col) < 32'(wc))
		else $error("raw column outside frame width");

	// square root and divider finish only while the sequencer waits for them
	a_sq_done: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> st_q == ST_SQRT)
		else $error("square root finished outside its wait state");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> st_q == ST_DIV)
		else $error("divider finished outside its wait state");

	// any edge class implies a nonzero kept magnitude
	a_class_mag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.edge_class != CLS_NONE |-> res_data.suppressed_magnitude != '0)
		else $error("edge class without magnitude");

endmodule
